// ===== rtl/two_button_gesture_decoder_core_defines.svh =====
// Assertion macros shared by the gesture decoder RTL.
// Depends on nothing; files that assert include it by name.
`ifndef TWO_BUTTON_GESTURE_DECODER_CORE_DEFINES_SVH
`define TWO_BUTTON_GESTURE_DECODER_CORE_DEFINES_SVH

// Condition and consequence checked at the same clock edge.
`define TBGD_ASSERT_NOW(lbl, cond, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) else $error(msg);

// Consequence checked at the clock edge after the condition.
`define TBGD_ASSERT_NEXT(lbl, cond, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) else $error(msg);

`endif

// ===== rtl/tbgd_pkg.sv =====
// Package for the two-button gesture decoder: event codes, register
// indexes, field widths and register reset values. No dependencies.
package tbgd_pkg;

   localparam int TICK_W  = 32;
   localparam int EVENT_W = 3;
   localparam int CSR_IDX_W = 2;

   typedef logic [TICK_W-1:0]    tick_type;
   typedef logic [EVENT_W-1:0]   event_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam event_type EV_NONE        = 3'd0;
   localparam event_type EV_LEFT_LONG   = 3'd1;
   localparam event_type EV_RIGHT_LONG  = 3'd2;
   localparam event_type EV_LEFT_SHORT  = 3'd3;
   localparam event_type EV_RIGHT_SHORT = 3'd4;
   localparam event_type EV_BOTH_TOGGLE = 3'd5;
   localparam event_type EV_MODE_SWITCH = 3'd6;

   localparam csr_idx_type CSR_LONG_PRESS  = 2'd0;
   localparam csr_idx_type CSR_MODE_SWITCH = 2'd1;

   localparam tick_type LONG_PRESS_RESET  = 32'd1000;
   localparam tick_type MODE_SWITCH_RESET = 32'd3000;

   localparam logic MODE_ARM_CONTROL = 1'b0;
   localparam logic MODE_SWERVE      = 1'b1;

endpackage

// ===== rtl/two_button_gesture_decoder_core.sv =====
// Two-button gesture decoder: one module, state and result register.
// Depends on tbgd_pkg and two_button_gesture_decoder_core_defines.svh.
//
// Usage:
//   req_* carries one sample of the two button levels and a free-running
//   32-bit tick count. Each accepted request produces exactly one response
//   on rsp_*: the event code, the mode after the sample and the toggle
//   request counter after the sample.
//   csr_* writes the long-press (index 0) and mode-switch (index 1) hold
//   times; other indexes are accepted and ignored. csr_ready is always high.
//   A request accepted at one edge is shown on rsp_* from the next edge.
//   Throughput is one request per cycle unless the receiver stalls; the decode is
//   a single pass of compare and subtract logic from the request ports and
//   the gesture state into the response register.
//   If the receiver stalls, the response register holds its contents and
//   req_ready drops until rsp_ready rises; a request is still taken in the
//   same cycle that the waiting response leaves.
//   Synchronous reset clears all gesture state, sets mode to arm control,
//   the counter to zero and the hold times to 1000 and 3000 ticks.
module two_button_gesture_decoder_core
   import tbgd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_left_pressed,
   input  logic        req_right_pressed,
   input  tick_type    req_now_ticks,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output event_type   rsp_event_res,
   output logic        rsp_mode,
   output tick_type    rsp_toggle_count,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  csr_idx_type csr_index,
   input  tick_type    csr_wdata
);

`include "two_button_gesture_decoder_core_defines.svh"

   // Configuration
   tick_type long_press_ff, long_press_in;
   tick_type mode_switch_ff, mode_switch_in;

   // Gesture state
   logic     prev_left_ff, prev_left_in;
   logic     prev_right_ff, prev_right_in;
   logic     both_seen_ff, both_seen_in;
   logic     both_long_ff, both_long_in;
   logic     left_long_ff, left_long_in;
   logic     right_long_ff, right_long_in;
   tick_type both_start_ff, both_start_in;
   tick_type left_start_ff, left_start_in;
   tick_type right_start_ff, right_start_in;
   logic     mode_ff, mode_in;
   tick_type count_ff, count_in;

   // Response register
   logic      rsp_valid_ff, rsp_valid_in;
   event_type rsp_event_ff, rsp_event_in;
   logic      rsp_mode_ff, rsp_mode_in;
   tick_type  rsp_id_ff, rsp_id_in;

   logic      req_fire;
   logic      cur_both, prev_both, cur_none, prev_any;
   logic      both_held, left_held, right_held;
   logic      left_rise, right_rise;
   logic      left_long_eff, right_long_eff;
   tick_type  left_start_eff, right_start_eff;
   event_type ev;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_res    = rsp_event_ff;
   assign rsp_mode         = rsp_mode_ff;
   assign rsp_toggle_count = rsp_id_ff;

   always_comb begin
      long_press_in  = long_press_ff;
      mode_switch_in = mode_switch_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_LONG_PRESS:  long_press_in  = csr_wdata;
            CSR_MODE_SWITCH: mode_switch_in = csr_wdata;
            default: ;
         endcase
      end
   end

   assign cur_both  = req_left_pressed && req_right_pressed;
   assign prev_both = prev_left_ff && prev_right_ff;
   assign cur_none  = !req_left_pressed && !req_right_pressed;
   assign prev_any  = prev_left_ff || prev_right_ff;

   // A fresh press restarts its timer in this very sample.
   assign left_rise       = req_left_pressed && !prev_left_ff;
   assign right_rise      = req_right_pressed && !prev_right_ff;
   assign left_start_eff  = left_rise ? req_now_ticks : left_start_ff;
   assign right_start_eff = right_rise ? req_now_ticks : right_start_ff;
   assign left_long_eff   = left_rise ? 1'b0 : left_long_ff;
   assign right_long_eff  = right_rise ? 1'b0 : right_long_ff;

   // Durations wrap modulo 2^32 and compare unsigned.
   assign both_held  = (req_now_ticks - both_start_ff) >= mode_switch_ff;
   assign left_held  = (req_now_ticks - left_start_eff) >= long_press_ff;
   assign right_held = (req_now_ticks - right_start_eff) >= long_press_ff;

   always_comb begin
      prev_left_in   = prev_left_ff;
      prev_right_in  = prev_right_ff;
      both_seen_in   = both_seen_ff;
      both_long_in   = both_long_ff;
      left_long_in   = left_long_ff;
      right_long_in  = right_long_ff;
      both_start_in  = both_start_ff;
      left_start_in  = left_start_ff;
      right_start_in = right_start_ff;
      mode_in        = mode_ff;
      count_in       = count_ff;
      ev             = EV_NONE;

      if (req_fire) begin
         if (cur_both) begin
            if (!both_seen_ff || (!prev_both && !both_long_ff)) begin
               both_start_in = req_now_ticks;
            end else if (!both_long_ff && both_held) begin
               both_long_in = 1'b1;
            end
         end
         // The sample that ends the both-pressed phase may still qualify.
         if (both_seen_ff && prev_both && !cur_both && !both_long_ff && both_held) begin
            both_long_in = 1'b1;
         end
         both_seen_in   = both_seen_ff || cur_both;
         left_start_in  = left_start_eff;
         right_start_in = right_start_eff;
         left_long_in   = left_long_eff;
         right_long_in  = right_long_eff;

         if (req_left_pressed && !both_seen_in && !left_long_eff && left_held) begin
            ev           = EV_LEFT_LONG;
            left_long_in = 1'b1;
         end
         if (req_right_pressed && !both_seen_in && !right_long_eff && right_held) begin
            ev            = EV_RIGHT_LONG;
            right_long_in = 1'b1;
         end

         if (cur_none && prev_any) begin
            if (both_seen_in) begin
               if (both_long_in) begin
                  mode_in = !mode_ff;
                  ev      = EV_MODE_SWITCH;
               end else begin
                  count_in = count_ff + tick_type'(1);
                  ev       = EV_BOTH_TOGGLE;
               end
            end else if (prev_right_ff && !prev_left_ff && !right_long_eff) begin
               count_in = count_ff + tick_type'(1);
               ev       = EV_RIGHT_SHORT;
            end else if (prev_left_ff && !prev_right_ff && !left_long_eff) begin
               count_in = count_ff + tick_type'(1);
               ev       = EV_LEFT_SHORT;
            end
            both_seen_in  = 1'b0;
            both_long_in  = 1'b0;
            left_long_in  = 1'b0;
            right_long_in = 1'b0;
         end

         prev_left_in  = req_left_pressed;
         prev_right_in = req_right_pressed;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_event_in = rsp_event_ff;
      rsp_mode_in  = rsp_mode_ff;
      rsp_id_in    = rsp_id_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
         rsp_event_in = ev;
         rsp_mode_in  = mode_in;
         rsp_id_in    = count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         long_press_ff  <= LONG_PRESS_RESET;
         mode_switch_ff <= MODE_SWITCH_RESET;
         prev_left_ff   <= 1'b0;
         prev_right_ff  <= 1'b0;
         both_seen_ff   <= 1'b0;
         both_long_ff   <= 1'b0;
         left_long_ff   <= 1'b0;
         right_long_ff  <= 1'b0;
         both_start_ff  <= '0;
         left_start_ff  <= '0;
         right_start_ff <= '0;
         mode_ff        <= MODE_ARM_CONTROL;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         long_press_ff  <= long_press_in;
         mode_switch_ff <= mode_switch_in;
         prev_left_ff   <= prev_left_in;
         prev_right_ff  <= prev_right_in;
         both_seen_ff   <= both_seen_in;
         both_long_ff   <= both_long_in;
         left_long_ff   <= left_long_in;
         right_long_ff  <= right_long_in;
         both_start_ff  <= both_start_in;
         left_start_ff  <= left_start_in;
         right_start_ff <= right_start_in;
         mode_ff        <= mode_in;
         count_ff       <= count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_event_ff <= rsp_event_in;
      rsp_mode_ff  <= rsp_mode_in;
      rsp_id_ff    <= rsp_id_in;
   end

   `TBGD_ASSERT_NEXT(a_fire_gives_rsp, req_fire, rsp_valid_ff,
      "accepted request lost its response")
   `TBGD_ASSERT_NEXT(a_state_holds_idle, !req_fire,
      $stable(mode_ff) && $stable(count_ff),
      "gesture state changed without a request")
   `TBGD_ASSERT_NOW(a_both_long_needs_seen, both_long_ff, both_seen_ff,
      "both-hold flag set outside a both-button gesture")
   `TBGD_ASSERT_NEXT(a_mode_flip_event, req_fire,
      (mode_ff != $past(mode_ff)) == (rsp_event_ff == EV_MODE_SWITCH),
      "mode changed without a mode switch event")
   `TBGD_ASSERT_NEXT(a_count_step_event, req_fire,
      (count_ff != $past(count_ff)) == (rsp_event_ff == EV_LEFT_SHORT ||
      rsp_event_ff == EV_RIGHT_SHORT || rsp_event_ff == EV_BOTH_TOGGLE),
      "counter step does not match the event")

endmodule

// ===== bench/two_button_gesture_decoder_core_test.sv =====
// Self-checking bench for two_button_gesture_decoder_core: button gestures go in,
// and each response is checked against a gesture predictor kept in the bench.
// Depends on tbgd_pkg and the core RTL.
module two_button_gesture_decoder_core_test
   import tbgd_pkg::*;
();

   typedef struct {
      logic     left;
      logic     right;
      tick_type now;
   } button_sample_type;

   typedef struct {
      event_type code;
      logic      mode;
      tick_type  toggle_count;
   } gesture_result_type;

   // This index is not used by the core, so a write to it must change nothing.
   localparam csr_idx_type CSR_SPARE = 2'd3;
   localparam int QUIET_LIMIT = 1000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_left_pressed = 1'b0;
   logic        req_right_pressed = 1'b0;
   tick_type    req_now_ticks = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   event_type   rsp_event_res;
   logic        rsp_mode;
   tick_type    rsp_toggle_count;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   csr_idx_type csr_index = CSR_LONG_PRESS;
   tick_type    csr_wdata = '0;

   button_sample_type  pending_samples[$];
   gesture_result_type expected_events[$];
   button_sample_type  next_sample;
   gesture_result_type wanted;
   int unsigned     samples_queued = 0;
   int unsigned     idle_pct = 0;
   int unsigned     send_gap = 0;
   int unsigned     hold_left = 0;
   int unsigned     quiet_cycles = 0;
   int unsigned     mismatches = 0;
   bit              long_stall_ask = 1'b0;
   tick_type        tick_now = 32'hFFFF_FC00;

   // Shadow copy of the hold times and of the gesture state.
   tick_type lp_ticks = LONG_PRESS_RESET;
   tick_type ms_ticks = MODE_SWITCH_RESET;
   logic     was_left = 1'b0, was_right = 1'b0;
   logic     both_seen = 1'b0, both_done = 1'b0;
   logic     left_done = 1'b0, right_done = 1'b0;
   tick_type both_t0 = '0, left_t0 = '0, right_t0 = '0;
   logic     mode_now = MODE_ARM_CONTROL;
   tick_type toggles = '0;

   two_button_gesture_decoder_core i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_left_pressed(req_left_pressed),
      .req_right_pressed(req_right_pressed),
      .req_now_ticks(req_now_ticks),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_event_res(rsp_event_res),
      .rsp_mode(rsp_mode),
      .rsp_toggle_count(rsp_toggle_count),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Durations wrap modulo 2^32 before the compare.
   function automatic logic held(tick_type now, tick_type start, tick_type limit);
      tick_type span;
      span = now - start;
      return span >= limit;
   endfunction

   function automatic gesture_result_type decode_sample(logic l, logic r, tick_type now);
      logic [1:0]         cur, prev;
      gesture_result_type res;
      cur = {l, r};
      prev = {was_left, was_right};
      res.code = EV_NONE;
      if (cur == 2'b11) begin
         if (!both_seen || (prev != 2'b11 && !both_done))
            both_t0 = now;
         else if (!both_done && held(now, both_t0, ms_ticks))
            both_done = 1'b1;
      end
      // The sample that ends the both-pressed phase still counts toward the hold.
      if (both_seen && prev == 2'b11 && cur != 2'b11 && !both_done &&
          held(now, both_t0, ms_ticks))
         both_done = 1'b1;
      if (cur == 2'b11)
         both_seen = 1'b1;
      if (l && !was_left) begin
         left_t0 = now;
         left_done = 1'b0;
      end
      if (r && !was_right) begin
         right_t0 = now;
         right_done = 1'b0;
      end
      if (l && !both_seen && !left_done && held(now, left_t0, lp_ticks)) begin
         res.code = EV_LEFT_LONG;
         left_done = 1'b1;
      end
      if (r && !both_seen && !right_done && held(now, right_t0, lp_ticks)) begin
         res.code = EV_RIGHT_LONG;
         right_done = 1'b1;
      end
      if (cur == 2'b00 && prev != 2'b00) begin
         if (both_seen) begin
            if (both_done) begin
               mode_now = (mode_now == MODE_SWERVE) ? MODE_ARM_CONTROL : MODE_SWERVE;
               res.code = EV_MODE_SWITCH;
            end else begin
               toggles++;
               res.code = EV_BOTH_TOGGLE;
            end
         end else if (prev == 2'b01 && !right_done) begin
            toggles++;
            res.code = EV_RIGHT_SHORT;
         end else if (prev == 2'b10 && !left_done) begin
            toggles++;
            res.code = EV_LEFT_SHORT;
         end
         both_seen = 1'b0;
         both_done = 1'b0;
         left_done = 1'b0;
         right_done = 1'b0;
      end
      was_left = l;
      was_right = r;
      res.mode = mode_now;
      res.toggle_count = toggles;
      return res;
   endfunction

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            expected_events.push_back(
               decode_sample(req_left_pressed, req_right_pressed, req_now_ticks));
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_samples.size() != 0 && $urandom_range(0, 99) < idle_pct) begin
               send_gap = $urandom_range(0, 15);
               req_valid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
               next_sample = pending_samples.pop_front();
               req_valid <= 1'b1;
               req_left_pressed <= next_sample.left;
               req_right_pressed <= next_sample.right;
               req_now_ticks <= next_sample.now;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response side: random stalls, plus one long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (long_stall_ask) begin
         long_stall_ask = 1'b0;
         hold_left = 59;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct) begin
         hold_left = $urandom_range(0, 15);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Response checker.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_events.size() == 0) begin
            $error("response with no request pending: event_res %0d", rsp_event_res);
            mismatches++;
         end else begin
            wanted = expected_events.pop_front();
            if (rsp_event_res !== wanted.code) begin
               $error("event_res expected %0d actual %0d", wanted.code, rsp_event_res);
               mismatches++;
            end
            if (rsp_mode !== wanted.mode) begin
               $error("mode expected %0d actual %0d", wanted.mode, rsp_mode);
               mismatches++;
            end
            if (rsp_toggle_count !== wanted.toggle_count) begin
               $error("toggle_count expected %0d actual %0d", wanted.toggle_count,
                      rsp_toggle_count);
               mismatches++;
            end
         end
      end
   end

   // Watchdog on cycles in which no channel moves anything.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("two_button_gesture_decoder_core_test failed");
            $finish;
         end
      end
   end

   task automatic put(logic l, logic r, tick_type adv);
      tick_now += adv;
      pending_samples.push_back('{l, r, tick_now});
      samples_queued++;
   endtask

   function automatic tick_type pick_hold(tick_type thr);
      case ($urandom_range(0, 5))
         0: return thr;
         1: return thr - 1;
         2: return thr + 1;
         3: return $urandom_range(0, 64);
         4: return thr + $urandom_range(1, 64);
         default: return $urandom;
      endcase
   endfunction

   function automatic tick_type release_ticks();
      case ($urandom_range(0, 2))
         0: return '0;
         1: return $urandom_range(1, 50);
         default: return pick_hold(ms_ticks);
      endcase
   endfunction

   // Spreads a hold of the given length over n samples at the same levels.
   task automatic hold_for(logic l, logic r, tick_type total, int n);
      tick_type left_over, step;
      left_over = total;
      for (int i = 0; i < n; i++) begin
         step = (i == n - 1) ? left_over : $urandom_range(0, left_over);
         put(l, r, step);
         left_over -= step;
      end
   endtask

   task automatic single_press();
      bit use_left;
      use_left = 1'($urandom_range(0, 1));
      put(use_left, !use_left, $urandom_range(0, 20));
      hold_for(use_left, !use_left, pick_hold(lp_ticks), $urandom_range(0, 3));
      put(1'b0, 1'b0, $urandom_range(0, 20));
   endtask

   task automatic both_press();
      int unsigned lead;
      bit          keep_left;
      lead = $urandom_range(0, 2);
      if (lead != 2) begin
         put(lead == 0, lead == 1, $urandom_range(0, 20));
         hold_for(lead == 0, lead == 1, pick_hold(lp_ticks), $urandom_range(0, 2));
      end
      put(1'b1, 1'b1, $urandom_range(0, 20));
      hold_for(1'b1, 1'b1, pick_hold(ms_ticks), $urandom_range(0, 3));
      if ($urandom_range(0, 3) == 0) begin
         // One button lets go and comes back before the gesture ends.
         keep_left = 1'($urandom_range(0, 1));
         put(keep_left, !keep_left, release_ticks());
         put(1'b1, 1'b1, $urandom_range(0, 20));
         hold_for(1'b1, 1'b1, pick_hold(ms_ticks), $urandom_range(0, 2));
      end
      if ($urandom_range(0, 2) == 0) begin
         put(1'b0, 1'b0, release_ticks());
      end else begin
         keep_left = 1'($urandom_range(0, 1));
         put(keep_left, !keep_left, release_ticks());
         hold_for(keep_left, !keep_left, pick_hold(lp_ticks), $urandom_range(0, 2));
         put(1'b0, 1'b0, $urandom_range(0, 20));
      end
   endtask

   task automatic random_gestures(int unsigned count);
      int unsigned stop_at, kind;
      stop_at = samples_queued + count;
      while (samples_queued < stop_at) begin
         kind = $urandom_range(0, 9);
         if (kind < 4) begin
            single_press();
         end else if (kind < 8) begin
            both_press();
         end else begin
            repeat ($urandom_range(1, 6))
               put(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   ($urandom_range(0, 1) != 0) ? tick_type'($urandom) : pick_hold(lp_ticks));
         end
      end
   endtask

   task automatic directed_gestures();
      put(1'b1, 1'b0, 5);          // left released just short of the long-press time
      put(1'b1, 1'b0, 999);
      put(1'b0, 1'b0, 1);
      put(1'b0, 1'b1, 1);          // right long press, then a silent release
      put(1'b0, 1'b1, 1000);
      put(1'b0, 1'b0, 1);
      put(1'b0, 1'b1, 1);          // right short press
      put(1'b0, 1'b0, 3);
      put(1'b1, 1'b0, 1);          // both held for the mode-switch time
      put(1'b1, 1'b1, 1);
      put(1'b1, 1'b1, 3000);
      put(1'b0, 1'b0, 1);
      put(1'b1, 1'b1, 1);          // quick both-button tap
      put(1'b0, 1'b0, 10);
      put(1'b1, 1'b1, 1);          // hold crosses the threshold on the releasing sample
      put(1'b1, 1'b0, 3000);
      put(1'b0, 1'b0, 1);
      put(1'b1, 1'b0, 1);          // left long press, then the right joins in
      put(1'b1, 1'b0, 32'hFFFF_FFFF);
      put(1'b1, 1'b1, 1);
      put(1'b0, 1'b0, 1);
      put(1'b0, 1'b0, 32'hFFFF_FFFF - tick_now);
      put(1'b0, 1'b0, 1);
   endtask

   task automatic write_regs(tick_type lp, tick_type ms);
      csr_idx_type idx[3];
      tick_type    val[3];
      idx = '{CSR_LONG_PRESS, CSR_MODE_SWITCH, CSR_SPARE};
      val = '{lp, ms, tick_type'($urandom)};
      for (int k = 0; k < 3; k++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[k];
         csr_wdata <= val[k];
         do @(posedge clock); while (!csr_ready);
         if (idx[k] == CSR_LONG_PRESS)
            lp_ticks = val[k];
         else if (idx[k] == CSR_MODE_SWITCH)
            ms_ticks = val[k];
      end
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      do @(posedge clock);
      while (pending_samples.size() != 0 || req_valid || expected_events.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      idle_pct = 15;
      directed_gestures();
      drain();
      write_regs('0, '0);
      idle_pct = 25;
      random_gestures(60);
      drain();
      write_regs('1, '1);
      idle_pct = 10;
      random_gestures(50);
      drain();
      write_regs($urandom_range(1, 5000), $urandom_range(1, 20000));
      idle_pct = 20;
      long_stall_ask = 1'b1;
      random_gestures(100);
      drain();
      write_regs($urandom, $urandom);
      idle_pct = 15;
      random_gestures(80);
      drain();
      // Closing stretch runs at full rate on both sides.
      write_regs($urandom_range(0, 200), $urandom_range(0, 800));
      idle_pct = 0;
      random_gestures(80);
      drain();
      repeat (4) @(posedge clock);
      if (mismatches == 0 && expected_events.size() == 0)
         $display("two_button_gesture_decoder_core_test passed");
      else
         $display("two_button_gesture_decoder_core_test failed");
      $finish;
   end

endmodule
